// ===== sv/eus_pkg.sv =====
// ----------------------------------------------------------------------------
// eus_pkg
// Shared widths, constants, register indexes and inter-module structs of the
// encoder unwrap and windowed speed estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package eus_pkg;

  // Ring of (time, position) snapshots.
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int ENT_W      = $clog2(RING_DEPTH + 1);

  // Field widths.
  localparam int ANGLE_W = 12;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 32;
  localparam int DELTA_W = 13;
  localparam int SPEED_W = 24;
  localparam int WIN_W   = 16;
  localparam int CPR_W   = 16;
  localparam int ENTRY_W = TIME_W + POS_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_COUNTS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 2'd2;

  localparam logic [WIN_W-1:0]   WINDOW_MS_RST   = 16'd200;
  localparam logic [CPR_W-1:0]   REV_COUNTS_RST  = 16'd4096;
  localparam logic [SPEED_W-1:0] NOISE_FLOOR_RST = 24'd16;

  // Opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REZERO = 1'b1;

  // Unwrap and speed arithmetic.
  localparam int HALF_REV = 2048;
  localparam int FULL_REV = 4096;
  localparam logic [TIME_W-1:0]  MIN_DT_US = 32'd5000;
  localparam logic [9:0]         MS_TO_US  = 10'd1000;
  localparam int SCALE_W = 30;
  localparam logic [SCALE_W-1:0] RPM_Q4_SCALE = 30'd960000000;
  localparam logic [SPEED_W-1:0] SPEED_MAX    = 24'hFFFFFF;

  // Divider operand widths.
  localparam int NUM_W = POS_W + SCALE_W;
  localparam int DEN_W = CPR_W + TIME_W;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/eus_if.sv =====
// ----------------------------------------------------------------------------
// eus_if
// Valid/ready stream interfaces for the sample channel and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface eus_in_if;
  import eus_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [ANGLE_W-1:0] angle;
  logic [TIME_W-1:0]  timestamp_us;

  modport source (output valid, output opcode, output angle, output timestamp_us,
                  input ready);
  modport sink   (input valid, input opcode, input angle, input timestamp_us,
                  output ready);
endinterface

interface eus_out_if;
  import eus_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DELTA_W-1:0] step_delta;
  logic signed [POS_W-1:0]   position;
  logic [SPEED_W-1:0]        speed_q4;

  modport source (output valid, output step_delta, output position, output speed_q4,
                  input ready);
  modport sink   (input valid, input step_delta, input position, input speed_q4,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/eus_ram.sv =====
// ----------------------------------------------------------------------------
// eus_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module eus_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/eus_div.sv =====
// ----------------------------------------------------------------------------
// eus_div
// Restoring divider for the speed quotient, one quotient bit per cycle,
// saturating to the full-scale speed when the quotient does not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module eus_div
  import eus_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int EXT_W = DEN_W + SPEED_W;
  localparam int CNT_W = $clog2(SPEED_W);

  typedef enum logic {D_IDLE, D_RUN} dstate_e;

  dstate_e            state_q, state_d;
  logic [NUM_W-1:0]   rem_q, rem_d;
  logic [EXT_W-1:0]   dsh_q, dsh_d;
  logic [SPEED_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;

  logic [EXT_W-1:0] num_ext;
  logic [EXT_W-1:0] den_top;
  logic [EXT_W-1:0] rem_ext;
  logic             fits;

  assign num_ext = EXT_W'(req_i.num);
  assign den_top = {req_i.den, SPEED_W'(0)};
  assign rem_ext = EXT_W'(rem_q);
  assign fits    = rem_ext >= dsh_q;

  // Next-state logic: saturation check at start, then one bit per cycle.
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          if (num_ext >= den_top) begin
            quot_d = SPEED_MAX;
            done_d = 1'b1;
          end else begin
            rem_d   = req_i.num;
            dsh_d   = EXT_W'({req_i.den, (SPEED_W - 1)'(0)});
            cnt_d   = CNT_W'(SPEED_W - 1);
            state_d = D_RUN;
          end
        end
      end
      D_RUN: begin
        if (fits) begin
          rem_d = NUM_W'(rem_ext - dsh_q);
        end
        quot_d = {quot_q[SPEED_W-2:0], fits};
        dsh_d  = dsh_q >> 1;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      rem_q   <= '0;
      dsh_q   <= '0;
      quot_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      dsh_q   <= dsh_d;
      quot_q  <= quot_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

// ===== sv/encoder_unwrap_speed_estimator_core.sv =====
// ----------------------------------------------------------------------------
// encoder_unwrap_speed_estimator_core
// Unwraps 12-bit absolute angles into a cumulative position and reports a
// windowed speed estimate in 1/16 rpm.
// ----------------------------------------------------------------------------
// Usage: samples arrive on sample_i (opcode, angle, timestamp_us); each sample
// beat yields exactly one beat on result_o (step_delta, position, speed_q4).
// A rezero beat clears the position, reseeds the unwrap and returns all zeros
// without touching the snapshot ring.
// Configuration (window, counts per revolution, noise floor) is written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write it only while the
// block is idle, and the block itself does not enforce this.
// An angle sample walks the snapshot RAM from its oldest entry, each entry a
// registered RAM read followed by a compare, for up to RING_DEPTH-1 entries of
// the 64-entry ring; the multiplies and a restoring divide follow. A saturated
// quotient ends the divide at its start, and an elapsed time under 5 ms skips
// the divide. Rezero beats and samples into a ring of fewer than two entries
// skip the walk.
// One sample is in work at a time; sample_i.ready is high while no sample is
// being processed, even while a finished result waits in the output register.
// When the receiver stalls, a finished result holds until the output register
// frees up. Reset clears position, unwrap state and ring pointers at once;
// the ring RAM needs no clearing pass since only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_unwrap_speed_estimator_core
  import eus_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  eus_in_if.sink                     sample_i,
  eus_out_if.source                  result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_CALC, S_DIVS, S_DIVW, S_DONE
  } state_e;

  localparam logic signed [ANGLE_W+1:0] HALF_S = (ANGLE_W + 2)'(HALF_REV);
  localparam logic signed [ANGLE_W+1:0] FULL_S = (ANGLE_W + 2)'(FULL_REV);
  localparam logic [RING_AW-1:0]        LAST_IDX = RING_AW'(RING_DEPTH - 1);

  // Configuration registers.
  logic [WIN_W-1:0]   window_ms_q;
  logic [CPR_W-1:0]   cpr_q;
  logic [SPEED_W-1:0] floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ms_q <= WINDOW_MS_RST;
      cpr_q       <= REV_COUNTS_RST;
      floor_q     <= NOISE_FLOOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_MS:   window_ms_q <= WIN_W'(cfg_wdata_i);
        CFG_REV_COUNTS:  cpr_q       <= CPR_W'(cfg_wdata_i);
        CFG_NOISE_FLOOR: floor_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e                    state_q, state_d;
  logic [ANGLE_W-1:0]        last_angle_q, last_angle_d;
  logic                      have_q, have_d;
  logic [POS_W-1:0]          cum_q, cum_d;
  logic [RING_AW-1:0]        head_q, head_d;
  logic                      full_q, full_d;
  logic [TIME_W-1:0]         now_q, now_d;
  logic signed [DELTA_W-1:0] delta_q, delta_d;
  logic [RING_AW-1:0]        walk_q, walk_d;
  logic [ENT_W-1:0]          remain_q, remain_d;
  logic                      first_q, first_d;
  logic [TIME_W-1:0]         ref_t_q, ref_t_d;
  logic [POS_W-1:0]          ref_p_q, ref_p_d;
  logic [NUM_W-1:0]          num_q, num_d;
  logic [DEN_W-1:0]          den_q, den_d;
  logic [SPEED_W-1:0]        speed_q, speed_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [DELTA_W-1:0] out_delta_q, out_delta_d;
  logic [POS_W-1:0]          out_pos_q, out_pos_d;
  logic [SPEED_W-1:0]        out_speed_q, out_speed_d;

  // Snapshot RAM and divider hookup.
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  eus_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (ram_wdata),
    .raddr_i (walk_q),
    .rdata_o (ram_rdata)
  );

  eus_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shortest-path unwrap of the incoming angle.
  logic signed [ANGLE_W+1:0] diff_raw, diff_adj;
  logic signed [DELTA_W-1:0] step_new;
  logic [POS_W-1:0]          cum_new;

  always_comb begin
    diff_raw = $signed({2'b00, sample_i.angle}) - $signed({2'b00, last_angle_q});
    diff_adj = diff_raw;
    if (diff_raw > HALF_S) begin
      diff_adj = diff_raw - FULL_S;
    end else if (diff_raw < -HALF_S) begin
      diff_adj = diff_raw + FULL_S;
    end
    step_new = have_q ? DELTA_W'(diff_adj) : '0;
    cum_new  = cum_q + {{(POS_W - DELTA_W){step_new[DELTA_W-1]}}, step_new};
  end

  // Ring pointers after pushing this sample.
  logic               wrap;
  logic [RING_AW-1:0] head_new;
  logic               full_new;
  logic [ENT_W-1:0]   entries_new;

  assign wrap        = (head_q == LAST_IDX);
  assign head_new    = wrap ? '0 : head_q + 1'b1;
  assign full_new    = full_q | wrap;
  assign entries_new = full_new ? ENT_W'(RING_DEPTH) : ENT_W'(head_new);

  // Walk compare and speed operands.
  logic [TIME_W-1:0] rd_time;
  logic [POS_W-1:0]  rd_pos;
  logic [TIME_W-1:0] win_us;
  logic              hit;
  logic [TIME_W-1:0] dt;
  logic [POS_W-1:0]  dc, mag;
  logic [CPR_W-1:0]  cpr_eff;

  assign rd_time = ram_rdata[ENTRY_W-1:POS_W];
  assign rd_pos  = ram_rdata[POS_W-1:0];
  assign win_us  = TIME_W'(window_ms_q) * TIME_W'(MS_TO_US);
  assign hit     = (now_q - rd_time) >= win_us;
  assign dt      = now_q - ref_t_q;
  assign dc      = cum_q - ref_p_q;
  assign mag     = dc[POS_W-1] ? (POS_W'(0) - dc) : dc;
  assign cpr_eff = (cpr_q == '0) ? CPR_W'(1) : cpr_q;

  assign ram_wdata = {sample_i.timestamp_us, cum_new};

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    last_angle_d = last_angle_q;
    have_d       = have_q;
    cum_d        = cum_q;
    head_d       = head_q;
    full_d       = full_q;
    now_d        = now_q;
    delta_d      = delta_q;
    walk_d       = walk_q;
    remain_d     = remain_q;
    first_d      = first_q;
    ref_t_d      = ref_t_q;
    ref_p_d      = ref_p_q;
    num_d        = num_q;
    den_d        = den_q;
    speed_d      = speed_q;
    out_valid_d  = out_valid_q;
    out_delta_d  = out_delta_q;
    out_pos_d    = out_pos_q;
    out_speed_d  = out_speed_q;
    ram_we       = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = num_q;
    div_req.den   = den_q;

    // The receiver drains the output register.
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (sample_i.valid) begin
          if (sample_i.opcode == OP_REZERO) begin
            cum_d   = '0;
            have_d  = 1'b0;
            delta_d = '0;
            speed_d = '0;
            state_d = S_DONE;
          end else begin
            cum_d        = cum_new;
            have_d       = 1'b1;
            last_angle_d = sample_i.angle;
            delta_d      = step_new;
            now_d        = sample_i.timestamp_us;
            ram_we       = 1'b1;
            head_d       = head_new;
            full_d       = full_new;
            speed_d      = '0;
            walk_d       = full_new ? head_new : '0;
            remain_d     = entries_new - 1'b1;
            first_d      = 1'b1;
            state_d      = (entries_new < ENT_W'(2)) ? S_DONE : S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        // The oldest entry is the fallback reference.
        if (first_q || hit) begin
          ref_t_d = rd_time;
          ref_p_d = rd_pos;
        end
        first_d = 1'b0;
        if (hit && (remain_q > ENT_W'(1))) begin
          walk_d   = (walk_q == LAST_IDX) ? '0 : walk_q + 1'b1;
          remain_d = remain_q - 1'b1;
          state_d  = S_READ;
        end else begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        num_d = NUM_W'(NUM_W'(mag) * NUM_W'(RPM_Q4_SCALE));
        den_d = DEN_W'(DEN_W'(cpr_eff) * DEN_W'(dt));
        if (dt < MIN_DT_US) begin
          speed_d = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_DIVS;
        end
      end
      S_DIVS: begin
        div_req.start = 1'b1;
        state_d       = S_DIVW;
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          speed_d = (div_rsp.quot < floor_q) ? '0 : div_rsp.quot;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_delta_d = delta_q;
          out_pos_d   = cum_q;
          out_speed_d = speed_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      last_angle_q <= '0;
      have_q       <= 1'b0;
      cum_q        <= '0;
      head_q       <= '0;
      full_q       <= 1'b0;
      now_q        <= '0;
      delta_q      <= '0;
      walk_q       <= '0;
      remain_q     <= '0;
      first_q      <= 1'b0;
      ref_t_q      <= '0;
      ref_p_q      <= '0;
      num_q        <= '0;
      den_q        <= '0;
      speed_q      <= '0;
      out_valid_q  <= 1'b0;
      out_delta_q  <= '0;
      out_pos_q    <= '0;
      out_speed_q  <= '0;
    end else begin
      state_q      <= state_d;
      last_angle_q <= last_angle_d;
      have_q       <= have_d;
      cum_q        <= cum_d;
      head_q       <= head_d;
      full_q       <= full_d;
      now_q        <= now_d;
      delta_q      <= delta_d;
      walk_q       <= walk_d;
      remain_q     <= remain_d;
      first_q      <= first_d;
      ref_t_q      <= ref_t_d;
      ref_p_q      <= ref_p_d;
      num_q        <= num_d;
      den_q        <= den_d;
      speed_q      <= speed_d;
      out_valid_q  <= out_valid_d;
      out_delta_q  <= out_delta_d;
      out_pos_q    <= out_pos_d;
      out_speed_q  <= out_speed_d;
    end
  end

  assign sample_i.ready      = (state_q == S_IDLE);
  assign result_o.valid      = out_valid_q;
  assign result_o.step_delta = out_delta_q;
  assign result_o.position   = $signed(out_pos_q);
  assign result_o.speed_q4   = out_speed_q;

endmodule

`default_nettype wire

// ===== sv/eus_checker.sv =====
// ----------------------------------------------------------------------------
// eus_checker
// Port-level checks of the speed estimator: result beats track sample beats,
// stalled results hold, and unwrap steps stay within half a revolution.
// ----------------------------------------------------------------------------
`default_nettype none

module eus_checker
  import eus_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic signed [DELTA_W-1:0] step_delta_i,
  input wire logic signed [POS_W-1:0]   position_i,
  input wire logic [SPEED_W-1:0]        speed_q4_i
);

  logic       in_beat, out_beat;
  logic [1:0] pend_q, pend_d;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Samples accepted whose result beat has not gone out yet.
  always_comb begin
    pend_d = pend_q;
    if (in_beat && !out_beat) begin
      pend_d = pend_q + 1'b1;
    end else if (!in_beat && out_beat) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A stalled result beat holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(step_delta_i)
      && $stable(position_i) && $stable(speed_q4_i))
    else $error("result beat changed while stalled");

  // No result appears without a sample behind it.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result beat without an accepted sample");

  // One sample in work plus one waiting result at most.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 2'd2)
    else $error("too many samples in flight");

  // Unwrap step stays within half a revolution either way.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (step_delta_i >= -13'sd2048) && (step_delta_i <= 13'sd2048))
    else $error("unwrap step out of range");

  // Reset holds the result channel empty.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result beat during reset");

endmodule

bind encoder_unwrap_speed_estimator_core eus_checker u_eus_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .step_delta_i (result_o.step_delta),
  .position_i   (result_o.position),
  .speed_q4_i   (result_o.speed_q4)
);

`default_nettype wire
